// File: rtl/lsbs_pkg.sv
// Shared types, constants and helpers for the LED strip blink scheduler.
package lsbs_pkg;

  localparam int LED_SLOTS     = 32;
  localparam int TICK_FRAME_MS = 200;

  localparam int TAB_AW     = $clog2(LED_SLOTS);
  localparam int WALK_W     = TAB_AW + 1;
  localparam int IDX_W      = 5;
  localparam int CNT_W      = 9;
  localparam int LEDS_W     = 6;
  localparam int LEDS_RESET = 32;
  localparam logic [CNT_W-1:0] PERIOD_MAX = '1;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_LEDS_IN_USE = 1'b0;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // floor(ms / TICK_FRAME_MS) by reciprocal multiply, exact for 16-bit ms
  localparam int RECIP_SHIFT = 26;
  localparam int RECIP_W     = 27;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((2**RECIP_SHIFT + TICK_FRAME_MS - 1) / TICK_FRAME_MS);
  localparam int PROD_W = 16 + RECIP_W;

  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_BLINK = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_PIXEL   = 2'd0,
    ACT_REFRESH = 2'd1,
    ACT_CLEAR   = 2'd2
  } action_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [TAB_AW-1:0] idx;
    logic [23:0]       rgb;
    logic [CNT_W-1:0]  lit_span;
    logic [CNT_W-1:0]  dark_span;
    logic              start_lit;
  } entry_t;

  function automatic logic [CNT_W-1:0] ms_to_ticks(input logic [15:0] ms);
    logic [PROD_W-1:0]             prod;
    logic [PROD_W-RECIP_SHIFT-1:0] q;
    prod = PROD_W'(ms) * PROD_W'(RECIP);
    q    = prod[PROD_W-1:RECIP_SHIFT];
    if (q > (PROD_W-RECIP_SHIFT)'(PERIOD_MAX)) begin
      return PERIOD_MAX;
    end
    return q[CNT_W-1:0];
  endfunction

endpackage

// File: rtl/lsbs_if.sv
// Command and result channel interfaces.
interface lsbs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [4:0]  led_index;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;
  logic [15:0] on_time_ms;
  logic [15:0] off_time_ms;
  logic        start_lit;

  modport source (output valid, cmd, led_index, red_in, green_in, blue_in,
                  on_time_ms, off_time_ms, start_lit, input ready);
  modport sink (input valid, cmd, led_index, red_in, green_in, blue_in,
                on_time_ms, off_time_ms, start_lit, output ready);
endinterface

interface lsbs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [4:0] pixel_index;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       last_of_run;

  modport source (output valid, action, pixel_index, red_out, green_out, blue_out,
                  last_of_run, input ready);
  modport sink (input valid, action, pixel_index, red_out, green_out, blue_out,
                last_of_run, output ready);
endinterface

// File: rtl/led_strip_blink_scheduler.sv
// LED strip blink scheduler top level: command intake, queue, execution, APB register.
// Commands are queued at intake; results are registered as the queue head executes.
// Set and set-blink emit 2 results, a pixel then a refresh; reset-all emits a clear.
// Tick walks min(leds_in_use, 32) LEDs, one per cycle unless an output stall holds it.
// A two-entry queue lets intake run ahead of the walk; output stalls pause the walk.
// Reset (rst, synchronous) clears the LED table at once and sets leds_in_use to 32.
module led_strip_blink_scheduler (
  input  logic                          clk,
  input  logic                          rst,
  lsbs_in_if.sink                       items,
  lsbs_out_if.source                    results,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lsbs_pkg::ADDR_W-1:0]   paddr,
  input  logic [lsbs_pkg::DATA_W-1:0]   pwdata,
  output logic [lsbs_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import lsbs_pkg::*;

  logic [LEDS_W-1:0] leds_in_use;
  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_empty;
  entry_t            push_entry;
  entry_t            head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LEDS_IN_USE) ? DATA_W'(leds_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      leds_in_use <= LEDS_W'(LEDS_RESET);
    end else if (psel && penable && pwrite && (paddr[2] == REG_LEDS_IN_USE)) begin
      leds_in_use <= pwdata[LEDS_W-1:0];
    end
  end

  lsbs_front u_front (
    .items      (items),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  lsbs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  lsbs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .leds_in_use (leds_in_use),
    .head        (head),
    .q_empty     (q_empty),
    .pop         (pop),
    .results     (results)
  );

endmodule

// File: rtl/lsbs_front.sv
// Command intake: range check, period conversion, push to the queue.
module lsbs_front (
  lsbs_in_if.sink          items,
  input  logic             q_full,
  output logic             push,
  output lsbs_pkg::entry_t push_entry
);
  import lsbs_pkg::*;

  cmd_t cmd;
  logic in_range;

  assign cmd         = cmd_t'(items.cmd);
  assign in_range    = ({1'b0, items.led_index} < (IDX_W+1)'(LED_SLOTS));
  assign items.ready = !q_full;
  assign push        = items.valid && !q_full &&
                       (in_range || (cmd == CMD_CLEAR) || (cmd == CMD_TICK));

  always_comb begin
    push_entry.cmd       = cmd;
    push_entry.idx       = TAB_AW'(items.led_index);
    push_entry.rgb       = {items.red_in, items.green_in, items.blue_in};
    push_entry.lit_span  = ms_to_ticks(items.on_time_ms);
    push_entry.dark_span = ms_to_ticks(items.off_time_ms);
    push_entry.start_lit = items.start_lit;
  end

endmodule

// File: rtl/lsbs_queue.sv
// Short command queue between intake and execution.
module lsbs_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lsbs_pkg::entry_t push_entry,
  input  logic             pop,
  output lsbs_pkg::entry_t head,
  output logic             full,
  output logic             empty
);
  import lsbs_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_entry;
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/lsbs_back.sv
// Command execution: LED table, tick walk and result register.
module lsbs_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [lsbs_pkg::LEDS_W-1:0] leds_in_use,
  input  lsbs_pkg::entry_t          head,
  input  logic                      q_empty,
  output logic                      pop,
  lsbs_out_if.source                results
);
  import lsbs_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_REFRESH, S_WALK} state_t;

  state_t            state;
  logic [23:0]       colour    [LED_SLOTS];
  logic              blink     [LED_SLOTS];
  logic              lit       [LED_SLOTS];
  logic [CNT_W-1:0]  tick_cnt  [LED_SLOTS];
  logic [CNT_W-1:0]  on_per    [LED_SLOTS];
  logic [CNT_W-1:0]  off_per   [LED_SLOTS];
  logic [WALK_W-1:0] walk;
  logic              any;

  logic              out_free;
  logic [TAB_AW-1:0] wa;
  logic [LEDS_W:0]   limit;
  logic              walk_done;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  period;
  logic              toggle;
  logic              load;

  assign out_free  = !results.valid || results.ready;
  assign pop       = (state == S_IDLE) && !q_empty && out_free;
  assign wa        = walk[TAB_AW-1:0];
  assign limit     = ({1'b0, leds_in_use} > (LEDS_W+1)'(LED_SLOTS)) ?
                     (LEDS_W+1)'(LED_SLOTS) : {1'b0, leds_in_use};
  assign walk_done = ((LEDS_W+1)'(walk) >= limit);

  always_comb begin
    cnt_inc = (tick_cnt[wa] < PERIOD_MAX) ? tick_cnt[wa] + 1'b1 : tick_cnt[wa];
    period  = lit[wa] ? on_per[wa] : off_per[wa];
    toggle  = (cnt_inc >= period);
  end

  always_comb begin
    case (state)
      S_IDLE:    load = pop && (head.cmd != CMD_TICK);
      S_REFRESH: load = out_free;
      S_WALK: begin
        if (walk_done) begin
          load = any && out_free;
        end else begin
          load = blink[wa] && toggle && out_free;
        end
      end
      default:   load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      results.valid <= 1'b0;
      walk          <= '0;
      any           <= 1'b0;
      for (int i = 0; i < LED_SLOTS; i++) begin
        colour[i]   <= '0;
        blink[i]    <= 1'b0;
        lit[i]      <= 1'b0;
        tick_cnt[i] <= '0;
        on_per[i]   <= '0;
        off_per[i]  <= '0;
      end
    end else begin
      results.valid <= load || (results.valid && !results.ready);
      case (state)
        S_IDLE: begin
          if (pop) begin
            case (head.cmd)
              CMD_SET: begin
                colour[head.idx]      <= head.rgb;
                blink[head.idx]       <= 1'b0;
                tick_cnt[head.idx]    <= '0;
                results.action        <= ACT_PIXEL;
                results.pixel_index   <= IDX_W'(head.idx);
                {results.red_out, results.green_out, results.blue_out} <= head.rgb;
                results.last_of_run   <= 1'b0;
                state                 <= S_REFRESH;
              end
              CMD_BLINK: begin
                colour[head.idx]      <= head.rgb;
                blink[head.idx]       <= 1'b1;
                tick_cnt[head.idx]    <= '0;
                lit[head.idx]         <= head.start_lit;
                on_per[head.idx]      <= head.lit_span;
                off_per[head.idx]     <= head.dark_span;
                results.action        <= ACT_PIXEL;
                results.pixel_index   <= IDX_W'(head.idx);
                {results.red_out, results.green_out, results.blue_out} <=
                  head.start_lit ? head.rgb : 24'd0;
                results.last_of_run   <= 1'b0;
                state                 <= S_REFRESH;
              end
              CMD_CLEAR: begin
                for (int i = 0; i < LED_SLOTS; i++) begin
                  colour[i]   <= '0;
                  blink[i]    <= 1'b0;
                  lit[i]      <= 1'b0;
                  tick_cnt[i] <= '0;
                end
                results.action        <= ACT_CLEAR;
                results.pixel_index   <= '0;
                {results.red_out, results.green_out, results.blue_out} <= 24'd0;
                results.last_of_run   <= 1'b1;
              end
              CMD_TICK: begin
                walk  <= '0;
                any   <= 1'b0;
                state <= S_WALK;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_REFRESH: begin
          if (out_free) begin
            results.action        <= ACT_REFRESH;
            results.pixel_index   <= '0;
            {results.red_out, results.green_out, results.blue_out} <= 24'd0;
            results.last_of_run   <= 1'b1;
            state                 <= S_IDLE;
          end
        end
        S_WALK: begin
          if (walk_done) begin
            if (!any) begin
              state <= S_IDLE;
            end else if (out_free) begin
              results.action        <= ACT_REFRESH;
              results.pixel_index   <= '0;
              {results.red_out, results.green_out, results.blue_out} <= 24'd0;
              results.last_of_run   <= 1'b1;
              state                 <= S_IDLE;
            end
          end else if (!blink[wa]) begin
            walk <= walk + 1'b1;
          end else if (!toggle) begin
            tick_cnt[wa] <= cnt_inc;
            walk         <= walk + 1'b1;
          end else if (out_free) begin
            tick_cnt[wa]          <= '0;
            lit[wa]               <= !lit[wa];
            any                   <= 1'b1;
            results.action        <= ACT_PIXEL;
            results.pixel_index   <= IDX_W'(walk);
            {results.red_out, results.green_out, results.blue_out} <=
              lit[wa] ? 24'd0 : colour[wa];
            results.last_of_run   <= 1'b0;
            walk                  <= walk + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the LED strip blink scheduler.
`timescale 1ns / 100ps

module testbench;
  import lsbs_pkg::*;

  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int SETTLE_CYCLES   = 120;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASES          = 6;
  localparam int PHASE_ITEMS     = 65;
  localparam logic [ADDR_W-1:0] LEDS_ADDR = ADDR_W'(4 * int'(REG_LEDS_IN_USE));

  typedef struct {
    cmd_t        cmd;
    logic [4:0]  led;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic        start_lit;
  } command_t;

  typedef struct {
    logic [1:0] act;
    logic [4:0] pixel;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } strip_action_t;

  class strip_scoreboard;
    logic [23:0]       colour    [LED_SLOTS];
    bit                blinking  [LED_SLOTS];
    bit                lit       [LED_SLOTS];
    logic [CNT_W-1:0]  count     [LED_SLOTS];
    logic [CNT_W-1:0]  lit_span  [LED_SLOTS];
    logic [CNT_W-1:0]  dark_span [LED_SLOTS];
    logic [LEDS_W-1:0] walk_len;
    strip_action_t     pending[$];
    int                mismatches;
    int                commands_seen;
    int                actions_checked;

    function new();
      foreach (colour[i]) begin
        colour[i]    = '0;
        blinking[i]  = 1'b0;
        lit[i]       = 1'b0;
        count[i]     = '0;
        lit_span[i]  = '0;
        dark_span[i] = '0;
      end
      walk_len = LEDS_W'(LEDS_RESET);
    endfunction

    function void set_walk_len(logic [LEDS_W-1:0] len);
      walk_len = len;
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    function void flag_error(string msg);
      mismatches++;
      if (mismatches <= 10) $display("ERROR at %0t: %s", $time, msg);
    endfunction

    function logic [CNT_W-1:0] period_of(logic [15:0] ms);
      int unsigned q;
      q = int'(ms) / TICK_FRAME_MS;
      return (q > 2**CNT_W - 1) ? CNT_W'(2**CNT_W - 1) : CNT_W'(q);
    endfunction

    function strip_action_t make_action(action_t act, logic [4:0] pixel, logic [23:0] rgb);
      strip_action_t a;
      a.act   = act;
      a.pixel = pixel;
      a.red   = rgb[23:16];
      a.green = rgb[15:8];
      a.blue  = rgb[7:0];
      a.last  = 1'b0;
      return a;
    endfunction

    function string describe(strip_action_t a);
      return $sformatf("act=%0d idx=%0d rgb=%02h%02h%02h last=%0b",
                       a.act, a.pixel, a.red, a.green, a.blue, a.last);
    endfunction

    function void note_command(command_t c);
      strip_action_t    run[$];
      logic [23:0]      rgb;
      logic [CNT_W-1:0] period;
      int unsigned      span;
      commands_seen++;
      rgb = {c.red, c.green, c.blue};
      case (c.cmd)
        CMD_SET, CMD_BLINK: begin
          colour[c.led] = rgb;
          count[c.led]  = '0;
          if (c.cmd == CMD_SET) begin
            blinking[c.led] = 1'b0;
            run.push_back(make_action(ACT_PIXEL, c.led, rgb));
          end else begin
            blinking[c.led]  = 1'b1;
            lit_span[c.led]  = period_of(c.on_ms);
            dark_span[c.led] = period_of(c.off_ms);
            lit[c.led]       = c.start_lit;
            run.push_back(make_action(ACT_PIXEL, c.led, c.start_lit ? rgb : 24'h0));
          end
          run.push_back(make_action(ACT_REFRESH, 5'd0, 24'h0));
        end
        CMD_CLEAR: begin
          foreach (colour[i]) begin
            colour[i]   = '0;
            blinking[i] = 1'b0;
            lit[i]      = 1'b0;
            count[i]    = '0;
          end
          run.push_back(make_action(ACT_CLEAR, 5'd0, 24'h0));
        end
        default: begin
          span = (walk_len > LED_SLOTS) ? LED_SLOTS : walk_len;
          for (int i = 0; i < span; i++) begin
            if (!blinking[i]) continue;
            if (count[i] != PERIOD_MAX) count[i]++;
            period = lit[i] ? lit_span[i] : dark_span[i];
            if (count[i] >= period) begin
              count[i] = '0;
              lit[i]   = !lit[i];
              run.push_back(make_action(ACT_PIXEL, 5'(i), lit[i] ? colour[i] : 24'h0));
            end
          end
          if (run.size() > 0) run.push_back(make_action(ACT_REFRESH, 5'd0, 24'h0));
        end
      endcase
      if (run.size() > 0) run[run.size()-1].last = 1'b1;
      foreach (run[k]) pending.push_back(run[k]);
    endfunction

    function void check_action(strip_action_t got);
      strip_action_t want;
      if (pending.size() == 0) begin
        flag_error($sformatf("unexpected action %s", describe(got)));
        return;
      end
      want = pending.pop_front();
      actions_checked++;
      if (got.act !== want.act || got.pixel !== want.pixel || got.red !== want.red ||
          got.green !== want.green || got.blue !== want.blue || got.last !== want.last)
        flag_error($sformatf("expected %s, got %s", describe(want), describe(got)));
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  lsbs_in_if  cmd_ch ();
  lsbs_out_if act_ch ();

  led_strip_blink_scheduler dut (
    .clk     (clk),
    .rst     (rst),
    .items   (cmd_ch),
    .results (act_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  strip_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_request;
  int phases_run;
  int lengths [5] = '{63, 1, 0, 32, 33};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    command_t      c;
    strip_action_t a;
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      c.cmd       = cmd_t'(cmd_ch.cmd);
      c.led       = cmd_ch.led_index;
      c.red       = cmd_ch.red_in;
      c.green     = cmd_ch.green_in;
      c.blue      = cmd_ch.blue_in;
      c.on_ms     = cmd_ch.on_time_ms;
      c.off_ms    = cmd_ch.off_time_ms;
      c.start_lit = cmd_ch.start_lit;
      sb.note_command(c);
    end
    if (!rst && act_ch.valid && act_ch.ready) begin
      a.act   = act_ch.action;
      a.pixel = act_ch.pixel_index;
      a.red   = act_ch.red_out;
      a.green = act_ch.green_out;
      a.blue  = act_ch.blue_out;
      a.last  = act_ch.last_of_run;
      sb.check_action(a);
    end
  end

  // hold ready low for a requested stretch, else stall at random
  initial begin
    forever begin
      @(negedge clk);
      if (stall_request > 0) begin
        act_ch.ready <= 1'b0;
        repeat (stall_request) @(negedge clk);
        stall_request = 0;
      end
      act_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (act_ch.valid && act_ch.ready) || psel)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: %0d cycles without a transaction", idle_cycles);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic command_t make_command(cmd_t cmd, logic [4:0] led, logic [23:0] rgb,
                                            logic [15:0] on_ms, logic [15:0] off_ms,
                                            logic start_lit);
    command_t c;
    c.cmd       = cmd;
    c.led       = led;
    c.red       = rgb[23:16];
    c.green     = rgb[15:8];
    c.blue      = rgb[7:0];
    c.on_ms     = on_ms;
    c.off_ms    = off_ms;
    c.start_lit = start_lit;
    return c;
  endfunction

  function automatic command_t random_command(int unsigned len);
    command_t    c;
    int unsigned pick;
    int unsigned span;
    pick = $urandom_range(99);
    span = (len > LED_SLOTS) ? LED_SLOTS : len;
    c.cmd = (pick < 45) ? CMD_TICK : (pick < 75) ? CMD_BLINK : (pick < 95) ? CMD_SET : CMD_CLEAR;
    c.led = (span > 0 && $urandom_range(1) == 1) ? 5'($urandom_range(span - 1))
                                                  : 5'($urandom_range(31));
    c.red       = 8'($urandom);
    c.green     = 8'($urandom);
    c.blue      = 8'($urandom);
    c.on_ms     = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(999));
    c.off_ms    = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(999));
    c.start_lit = 1'($urandom);
    return c;
  endfunction

  task automatic send_command(input command_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.cmd         <= c.cmd;
    cmd_ch.led_index   <= c.led;
    cmd_ch.red_in      <= c.red;
    cmd_ch.green_in    <= c.green;
    cmd_ch.blue_in     <= c.blue;
    cmd_ch.on_time_ms  <= c.on_ms;
    cmd_ch.off_time_ms <= c.off_ms;
    cmd_ch.start_lit   <= c.start_lit;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_for_actions(input int settle);
    do @(negedge clk); while (sb.outstanding() != 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic apb_access(input logic write_op, input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write_op;
    paddr   <= LEDS_ADDR;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_strip_length(input logic [LEDS_W-1:0] len);
    logic [DATA_W-1:0] readback;
    apb_access(1'b1, DATA_W'(len), readback);
    sb.set_walk_len(len);
    apb_access(1'b0, '0, readback);
    if (readback !== DATA_W'(len))
      sb.flag_error($sformatf("leds_in_use read back %0h, wrote %0h", readback, len));
  endtask

  initial begin
    command_t directed[$];
    int       len;
    sb = new();
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    cmd_ch.valid       = 1'b0;
    cmd_ch.cmd         = CMD_SET;
    cmd_ch.led_index   = '0;
    cmd_ch.red_in      = '0;
    cmd_ch.green_in    = '0;
    cmd_ch.blue_in     = '0;
    cmd_ch.on_time_ms  = '0;
    cmd_ch.off_time_ms = '0;
    cmd_ch.start_lit   = 1'b0;
    act_ch.ready       = 1'b0;
    stall_request      = 0;
    phases_run         = 0;
    send_idle_pct      = 11;
    recv_idle_pct      = 67;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part at the reset strip length
    directed.push_back(make_command(CMD_SET,   5'd0,  24'hFFFFFF, 16'd0,     16'd0,     1'b1));
    directed.push_back(make_command(CMD_SET,   5'd31, 24'h000000, 16'hFFFF,  16'hFFFF,  1'b0));
    directed.push_back(make_command(CMD_BLINK, 5'd1,  24'h123456, 16'd0,     16'd0,     1'b1));
    directed.push_back(make_command(CMD_BLINK, 5'd2,  24'hFFFFFF, 16'hFFFF,  16'hFFFF,  1'b0));
    directed.push_back(make_command(CMD_BLINK, 5'd3,  24'hA5C3E7, 16'd199,   16'd200,   1'b0));
    directed.push_back(make_command(CMD_BLINK, 5'd31, 24'h805A01, 16'd400,   16'd600,   1'b1));
    repeat (4)
      directed.push_back(make_command(CMD_TICK, 5'd0, 24'h0, 16'd0, 16'd0, 1'b0));
    directed.push_back(make_command(CMD_SET,   5'd1,  24'h0F0F0F, 16'd0,     16'd0,     1'b0));
    directed.push_back(make_command(CMD_TICK,  5'd0,  24'h0,      16'd0,     16'd0,     1'b0));
    directed.push_back(make_command(CMD_CLEAR, 5'd0,  24'h0,      16'd0,     16'd0,     1'b0));
    directed.push_back(make_command(CMD_TICK,  5'd0,  24'h0,      16'd0,     16'd0,     1'b0));
    directed.push_back(make_command(CMD_BLINK, 5'd0,  24'h7F80FE, 16'd0,     16'd0,     1'b0));
    directed.push_back(make_command(CMD_BLINK, 5'd30, 24'h010203, 16'd1000,  16'd0,     1'b1));
    repeat (3)
      directed.push_back(make_command(CMD_TICK, 5'd0, 24'h0, 16'd0, 16'd0, 1'b0));
    foreach (directed[k]) send_command(directed[k]);
    cmd_ch.valid <= 1'b0;
    wait_for_actions(SETTLE_CYCLES);

    for (int p = 0; p < PHASES; p++) begin
      len           = (p < 5) ? lengths[p] : $urandom_range(2, 31);
      send_idle_pct = (p < 2) ? 11 : (p < 4) ? 67 : 0;
      recv_idle_pct = (p < 2) ? 67 : (p < 4) ? 11 : 0;
      set_strip_length(LEDS_W'(len));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 4 && n == PHASE_ITEMS / 2) stall_request = HOLD_OFF_CYCLES;
        if (p == 2 && n == PHASE_ITEMS / 2) begin
          cmd_ch.valid <= 1'b0;
          wait_for_actions(0);
        end
        send_command(random_command(len));
      end
      cmd_ch.valid <= 1'b0;
      wait_for_actions(SETTLE_CYCLES);
      phases_run++;
    end

    $display("run: %0d commands, %0d strip actions checked", sb.commands_seen,
             sb.actions_checked);
    $display("run: %0d strip lengths incl. 0, 1, 32, 33, 63; receiver hold-off and drains",
             phases_run);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/lsbs_pkg.sv
rtl/lsbs_if.sv
rtl/lsbs_front.sv
rtl/lsbs_queue.sv
rtl/lsbs_back.sv
rtl/led_strip_blink_scheduler.sv
tb/testbench.sv
